// File: rtl/tlvp_pkg.sv
// Shared types and constants for the TLV stream parser.
// Depends on nothing; the top level and the record parser use it.
package tlvp_pkg;

  // Input item operation codes.
  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_END    = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Result kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam int FIELD_W = 11;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 11'd2047;

  localparam int TABLE_DEPTH_DEF     = 128;
  localparam int MAX_FRAME_BYTES_DEF = 2048;

  // Table update that the record parser asks for.
  typedef struct packed {
    logic               store;
    logic [15:0]        tag;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] length;
  } store_req_t;

  // Frame-level events from the record parser.
  typedef struct packed {
    logic clear_table;
    logic end_bad;
  } frame_evt_t;

  // Clamp a value to the largest 11-bit field value.
  function automatic logic [FIELD_W-1:0] sat11(input logic [16:0] v);
    logic [FIELD_W-1:0] r;
    if (v > 17'(FIELD_MAX)) begin
      r = FIELD_MAX;
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/tlv_stream_parser.sv
// Top level of the TLV stream parser: request handshake, entry table, result stage.
// Depends on tlvp_pkg, tlvp_rec_parser and tlvp_table_ram.
//
// Usage. Requests arrive on the in_ channel (valid/ready), one per cycle at most:
// a frame byte, an end-of-frame marker or a lookup of a tag. Frame bytes give no
// result. An end request returns the frame status and a lookup returns the stored
// payload offset and length for the tag; both leave on the out_ channel in
// request order. While in_ready is high the block takes one request per clock. A
// result passes through the pending stage and then the output register: the
// accepting edge loads the pending stage and does the synchronous table read,
// and the output register loads from it when free or drained. The table lives
// in a one-read, one-write memory; a byte that completes a record writes it in
// its own cycle, so a lookup in the next cycle already sees it. Per-entry valid
// bits in flip-flops let a new frame empty the table at once.
// After reset no frame is open, the table is empty and no result is pending.
// When the receiver stalls, a pending result waits in a stage ahead of the output
// register; in_ready falls only when both that stage and the output register are
// occupied and out_ready is low.
module tlv_stream_parser #(
  parameter int TABLE_DEPTH     = tlvp_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_FRAME_BYTES = tlvp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_data_byte,
  input  logic [6:0]  in_query_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_answer_kind,
  output logic        out_frame_status,
  output logic        out_entry_present,
  output logic [10:0] out_entry_offset,
  output logic [10:0] out_entry_length
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW = 2 * tlvp_pkg::FIELD_W;
  localparam logic [16:0] DEPTH_LIM = 17'(TABLE_DEPTH);

  logic accept, byte_take, end_take, look_take;

  tlvp_pkg::store_req_t store_req;
  tlvp_pkg::frame_evt_t frame_evt;

  // Pending result stage (table read in flight) and output register.
  logic        pend_r, pend_nxt;
  logic        pend_kind_r, pend_status_r, pend_present_r;
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_status_r, out_present_r;
  logic [10:0] out_offset_r, out_length_r;
  logic        pend_move;

  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic                   wr_in_table, rd_in_table, rd_hit;
  logic [15:0]            qtag16;
  logic [DW-1:0]          rd_data;

  assign in_ready  = !pend_r || !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign byte_take = accept && (in_op == tlvp_pkg::OP_BYTE);
  assign end_take  = accept && (in_op == tlvp_pkg::OP_END);
  assign look_take = accept && (in_op == tlvp_pkg::OP_LOOKUP);

  tlvp_rec_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .end_take  (end_take),
    .data_byte (in_data_byte),
    .store_req (store_req),
    .frame_evt (frame_evt)
  );

  // Records with a tag beyond the table are parsed but never stored.
  assign wr_in_table = store_req.store && (17'(store_req.tag) < DEPTH_LIM);
  assign qtag16      = 16'(in_query_tag);
  assign rd_in_table = 17'(qtag16) < DEPTH_LIM;
  assign rd_hit      = rd_in_table && valid_r[qtag16[AW-1:0]];

  tlvp_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk   (clk),
    .we    (wr_in_table),
    .waddr (store_req.tag[AW-1:0]),
    .wdata ({store_req.offset, store_req.length}),
    .re    (look_take && rd_in_table),
    .raddr (qtag16[AW-1:0]),
    .rdata (rd_data)
  );

  // Valid bits: a new frame (or an end with no frame open) empties the table.
  always_comb begin
    valid_nxt = valid_r;
    if (frame_evt.clear_table) begin
      valid_nxt = '0;
    end
    if (wr_in_table) begin
      valid_nxt[store_req.tag[AW-1:0]] = 1'b1;
    end
  end

  // The pending stage moves on whenever the output register is free or drained.
  assign pend_move     = pend_r && (!out_valid_r || out_ready);
  assign pend_nxt      = (end_take || look_take) || (pend_r && !pend_move);
  assign out_valid_nxt = pend_move || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (end_take || look_take) begin
      pend_kind_r    <= end_take ? tlvp_pkg::KIND_STATUS : tlvp_pkg::KIND_LOOKUP;
      pend_status_r  <= end_take && frame_evt.end_bad;
      pend_present_r <= look_take && rd_hit;
    end
    if (pend_move) begin
      out_kind_r    <= pend_kind_r;
      out_status_r  <= pend_status_r;
      out_present_r <= pend_present_r;
      out_offset_r  <= pend_present_r ? rd_data[DW-1:tlvp_pkg::FIELD_W] : 11'd0;
      out_length_r  <= pend_present_r ? rd_data[tlvp_pkg::FIELD_W-1:0] : 11'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_answer_kind   = out_kind_r;
  assign out_frame_status  = out_status_r;
  assign out_entry_present = out_present_r;
  assign out_entry_offset  = out_offset_r;
  assign out_entry_length  = out_length_r;

endmodule

// File: rtl/tlvp_table_ram.sv
// Single write port, single read port table memory with registered read data.
// Depends on nothing outside this file.
module tlvp_table_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 22
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/tlvp_rec_parser.sv
// Byte-level record parser: header assembly, payload counting, frame checks.
// Depends on tlvp_pkg for the request and event types and the clamp function.
module tlvp_rec_parser #(
  parameter int MAX_FRAME_BYTES = tlvp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_take,
  input  logic                 end_take,
  input  logic [7:0]           data_byte,
  output tlvp_pkg::store_req_t store_req,
  output tlvp_pkg::frame_evt_t frame_evt
);

  localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_FRAME_BYTES);

  logic             frame_open_r, frame_open_nxt;
  logic [1:0]       hbc_r, hbc_nxt;
  logic             in_pay_r, in_pay_nxt;
  logic [15:0]      hlen_r, hlen_nxt;
  logic [15:0]      htag_r, htag_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [10:0]      rstart_r, rstart_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic             bad_r, bad_nxt;

  // Values as seen by a byte: a closed frame starts from cleared counters.
  logic             c_hbc_z;
  logic [1:0]       c_hbc;
  logic             c_in_pay;
  logic [15:0]      c_hlen, c_htag, c_rem;
  logic [10:0]      c_rstart;
  logic [OFF_W-1:0] c_off;
  logic             c_bad;

  always_comb begin
    c_hbc_z  = !frame_open_r;
    c_hbc    = c_hbc_z ? 2'd0 : hbc_r;
    c_in_pay = c_hbc_z ? 1'b0 : in_pay_r;
    c_hlen   = c_hbc_z ? 16'd0 : hlen_r;
    c_htag   = c_hbc_z ? 16'd0 : htag_r;
    c_rem    = c_hbc_z ? 16'd0 : rem_r;
    c_rstart = c_hbc_z ? 11'd0 : rstart_r;
    c_off    = c_hbc_z ? '0 : off_r;
    c_bad    = c_hbc_z ? 1'b0 : bad_r;

    frame_open_nxt = frame_open_r;
    hbc_nxt        = hbc_r;
    in_pay_nxt     = in_pay_r;
    hlen_nxt       = hlen_r;
    htag_nxt       = htag_r;
    rem_nxt        = rem_r;
    rstart_nxt     = rstart_r;
    off_nxt        = off_r;
    bad_nxt        = bad_r;

    store_req       = '0;
    frame_evt       = '0;

    if (byte_take) begin
      frame_evt.clear_table = !frame_open_r;
      frame_open_nxt = 1'b1;
      hbc_nxt        = c_hbc;
      in_pay_nxt     = c_in_pay;
      hlen_nxt       = c_hlen;
      htag_nxt       = c_htag;
      rem_nxt        = c_rem;
      rstart_nxt     = c_rstart;
      off_nxt        = c_off;
      bad_nxt        = c_bad;
      if (c_off >= MAX_OFF) begin
        // Frame too long: flag it and drop the byte.
        bad_nxt = 1'b1;
      end else begin
        off_nxt = c_off + 1'b1;
        if (c_in_pay) begin
          rem_nxt = c_rem - 16'd1;
          if (rem_nxt == 16'd0) begin
            in_pay_nxt       = 1'b0;
            store_req.store  = 1'b1;
            store_req.tag    = c_htag;
            store_req.offset = c_rstart;
            store_req.length = tlvp_pkg::sat11(17'(c_hlen));
          end
        end else begin
          case (c_hbc)
            2'd0:    hlen_nxt = {8'h00, data_byte};
            2'd1:    hlen_nxt = {data_byte, c_hlen[7:0]};
            2'd2:    htag_nxt = {8'h00, data_byte};
            default: htag_nxt = {data_byte, c_htag[7:0]};
          endcase
          if (c_hbc != 2'd3) begin
            hbc_nxt = c_hbc + 2'd1;
          end else begin
            hbc_nxt    = 2'd0;
            rstart_nxt = tlvp_pkg::sat11(17'(c_off) + 17'd1);
            if (hlen_nxt == 16'd0) begin
              store_req.store  = 1'b1;
              store_req.tag    = htag_nxt;
              store_req.offset = rstart_nxt;
              store_req.length = '0;
            end else begin
              in_pay_nxt = 1'b1;
              rem_nxt    = hlen_nxt;
            end
          end
        end
      end
    end else if (end_take) begin
      frame_evt.end_bad     = frame_open_r && (bad_r || (hbc_r != 2'd0) || in_pay_r);
      frame_evt.clear_table = !frame_open_r;
      frame_open_nxt = 1'b0;
      hbc_nxt        = 2'd0;
      in_pay_nxt     = 1'b0;
      hlen_nxt       = 16'd0;
      htag_nxt       = 16'd0;
      rem_nxt        = 16'd0;
      rstart_nxt     = 11'd0;
      off_nxt        = '0;
      bad_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      hbc_r        <= 2'd0;
      in_pay_r     <= 1'b0;
      hlen_r       <= 16'd0;
      htag_r       <= 16'd0;
      rem_r        <= 16'd0;
      rstart_r     <= 11'd0;
      off_r        <= '0;
      bad_r        <= 1'b0;
    end else begin
      frame_open_r <= frame_open_nxt;
      hbc_r        <= hbc_nxt;
      in_pay_r     <= in_pay_nxt;
      hlen_r       <= hlen_nxt;
      htag_r       <= htag_nxt;
      rem_r        <= rem_nxt;
      rstart_r     <= rstart_nxt;
      off_r        <= off_nxt;
      bad_r        <= bad_nxt;
    end
  end

endmodule
